@@ sv/ntcti_pkg.sv @@
// Shared widths, register indexes, request codes and constants of the NTC table interpolation unit.
package ntcti_pkg;

	localparam int ADC_IN_W   = 10;
	localparam int IDX_W      = 5;
	localparam int STEP_W     = 10;
	localparam int TEMP_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_ADC_BITS    = 10;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_TEMP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_STEP = 1'b1;

	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	localparam int TEMP_MAX = 32767;
	localparam logic signed [TEMP_W-1:0] TEMP_ERR = -16'sd32767;
	localparam logic [STEP_W-1:0] STEP_RESET = 10'd50;

endpackage

@@ sv/ntcti_table.sv @@
// Breakpoint table: one write port, one registered read port, per-entry valid bits.
module ntcti_table
	import ntcti_pkg::*;
#(
	parameter int DEPTH = DEF_TABLE_DEPTH,
	parameter int WIDTH = DEF_ADC_BITS,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdat_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdat_q <= mem[rd_addr];
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rvld_q ? rdat_q : '0;

endmodule

@@ sv/ntcti_div.sv @@
// Restoring divider producing one quotient bit per cycle for a quotient known to fit Q_W bits.
module ntcti_div
	import ntcti_pkg::*;
#(
	parameter int NUM_W = DEF_ADC_BITS + STEP_W,
	parameter int Q_W   = STEP_W,
	localparam int DEN_W = NUM_W - Q_W,
	localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quot
);

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             fits;

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'(den) << (Q_W - 1);
			quot_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ sv/ntc_table_interpolation_unit.sv @@
// Top level of the NTC thermistor table interpolation unit.
// Requests arrive on the req channel (req_valid, req_stall). A write request
// stores entry_value at entry_index in the breakpoint table and gives no
// result word. A convert request walks the table from entry 0, one entry per
// cycle from the table memory, until it finds the first entry that is not
// above adc_sample. It then forms (hi - sample) * step, divides by (hi - lo)
// one quotient bit per cycle, adds the segment base and base_temp, and
// saturates. An out-of-range word follows the walk directly. Requests are
// taken one at a time; the next is accepted once the previous result is in
// the output register.
// Results leave on the res channel (res_valid, res_stall). While res_stall is
// high the result word holds, and the unit still accepts writes and runs the
// next convert up to its final cycle, where it waits for the register to free.
// Configuration (base_temp, temp_step) is written on the cfg channel, which
// is always ready and must only be used while the unit is idle.
// Reset clears the table to zeros through per-entry valid bits, so there is
// no clearing pass; base_temp resets to 0 and temp_step to 50.
module ntc_table_interpolation_unit
	import ntcti_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int ADC_BITS    = DEF_ADC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     req_type,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic [ADC_IN_W-1:0]      entry_value,
	input  logic [ADC_IN_W-1:0]      adc_sample,

	output logic                     res_valid,
	input  logic                     res_stall,
	output logic signed [TEMP_W-1:0] temperature,
	output logic                     out_of_range,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	// Address width of the table, compare width of samples and entries, and
	// the widths of the products and the final sum.
	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW     = (ADC_BITS > ADC_IN_W) ? ADC_BITS : ADC_IN_W;
	localparam int NUM_W  = CW + STEP_W;
	localparam int BASE_W = AW + STEP_W;
	localparam int SUM_W  = ((BASE_W + 1 > TEMP_W) ? BASE_W + 1 : TEMP_W) + 1;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(TEMP_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-TEMP_MAX);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]               state_q;
	logic [AW-1:0]            pos_q;
	logic [CW-1:0]            sample_q;
	logic [CW-1:0]            hi_q;
	logic [CW-1:0]            lo_q;
	logic [NUM_W-1:0]         num_q;
	logic [CW-1:0]            den_q;
	logic [BASE_W-1:0]        base_q;
	logic [STEP_W-1:0]        quot_q;
	logic                     oor_q;
	logic                     start_q;

	logic signed [TEMP_W-1:0] base_temp_q;
	logic [STEP_W-1:0]        temp_step_q;

	logic                     res_valid_q;
	logic signed [TEMP_W-1:0] temperature_q;
	logic                     oor_out_q;

	logic                     req_acc;
	logic                     tbl_wr_en;
	logic [AW-1:0]            tbl_rd_addr;
	logic [ADC_BITS-1:0]      tbl_rd_data;
	logic [CW-1:0]            entry;
	logic                     div_done;
	logic [STEP_W-1:0]        div_quot;
	logic                     res_free;
	logic [SUM_W-1:0]         mag;
	logic signed [SUM_W-1:0]  sum;
	logic signed [TEMP_W-1:0] sat_temp;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// Writes past the end of the table are dropped; wide values keep their
	// low ADC_BITS bits.
	assign tbl_wr_en = req_acc && (req_type == REQ_WRITE) && (32'(entry_index) < TABLE_DEPTH);

	// The read port runs every cycle: entry 0 while idle, so that a convert
	// accepted now sees entry 0 in its first walk cycle, then one entry ahead.
	assign tbl_rd_addr = (state_q == S_WALK) ? AW'(pos_q + 1'b1) : '0;

	ntcti_table #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (ADC_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr_en),
		.wr_addr (AW'(entry_index)),
		.wr_data (ADC_BITS'(entry_value)),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

	assign entry = CW'(tbl_rd_data);

	// The quotient never exceeds temp_step, since lo <= sample < hi.
	ntcti_div #(
		.NUM_W (NUM_W),
		.Q_W   (STEP_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Final sum of quotient, segment base and offset, then saturation.
	assign mag      = SUM_W'(base_q) + SUM_W'(quot_q);
	assign sum      = signed'(mag) + SUM_W'(base_temp_q);
	assign sat_temp = (sum > SAT_HI) ? TEMP_W'(SAT_HI) :
	                  (sum < SAT_LO) ? TEMP_W'(SAT_LO) : TEMP_W'(sum);

	assign res_free = !res_valid_q || !res_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_temp_q <= '0;
			temp_step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_TEMP: base_temp_q <= signed'(cfg_data);
				REG_TEMP_STEP: temp_step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath registers of the walk, the products and the quotient.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sample_q <= CW'(adc_sample);
			end
			S_WALK: begin
				if (sample_q < entry) begin
					hi_q <= entry;
				end
				lo_q <= entry;
			end
			S_MUL: begin
				num_q  <= NUM_W'(hi_q - sample_q) * NUM_W'(temp_step_q);
				den_q  <= hi_q - lo_q;
				base_q <= BASE_W'(AW'(pos_q - 1'b1)) * BASE_W'(temp_step_q);
			end
			S_DIV: begin
				quot_q <= div_quot;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// Sequencer. hi_q keeps the last entry above the sample; in the stop
	// cycle lo_q takes the entry that ended the walk, and hi_q is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			oor_q   <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && (req_type == REQ_CONVERT)) begin
						state_q <= S_WALK;
						pos_q   <= '0;
						oor_q   <= 1'b0;
					end
				end
				S_WALK: begin
					if (sample_q < entry) begin
						if (pos_q == AW'(TABLE_DEPTH - 1)) begin
							oor_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end else if (pos_q == '0) begin
						oor_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					start_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && res_free) begin
			temperature_q <= oor_q ? TEMP_ERR : sat_temp;
			oor_out_q     <= oor_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign temperature  = temperature_q;
	assign out_of_range = oor_out_q;

	// The divider only reports completion while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider completion outside the divide state");

	// The bracketing entries always give a positive divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (den_q != '0))
		else $error("zero divisor in the divide state");

	// An out-of-range result always carries the error temperature.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_of_range) |-> (temperature == TEMP_ERR))
		else $error("out-of-range result without the error temperature");

	// A finished result is never dropped while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("result word lost under stall");

endmodule
